FILE: rtl/tgp_pkg.sv
// Package for the turtle grid plotter: grid size, derived widths,
// command and status codes, and the controller-to-datapath command bundle.
// No dependencies.
`default_nettype none

package tgp_pkg;

    // Grid size; the store holds at most 32 rows of at most 64 columns
    localparam int GRID_ROWS = 32;
    localparam int GRID_COLS = 64;

    localparam int ROWS_USED = (GRID_ROWS > 32) ? 32 : GRID_ROWS;
    localparam int COLS_USED = (GRID_COLS > 64) ? 64 : GRID_COLS;

    // Internal position widths
    localparam int RW = $clog2(ROWS_USED);
    localparam int CW = $clog2(COLS_USED);

    // Port widths fixed by the result format
    localparam int OP_W     = 3;
    localparam int DIST_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ROW_OW   = 5;
    localparam int COL_OW   = 6;
    localparam int HEAD_W   = 2;
    localparam int BITS_OW  = 64;

    // Command codes
    localparam logic [OP_W-1:0] OP_PEN_UP  = 3'd0;
    localparam logic [OP_W-1:0] OP_PEN_DN  = 3'd1;
    localparam logic [OP_W-1:0] OP_RIGHT   = 3'd2;
    localparam logic [OP_W-1:0] OP_LEFT    = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd4;
    localparam logic [OP_W-1:0] OP_DISPLAY = 3'd5;
    localparam logic [OP_W-1:0] OP_END     = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 2'd2;

    // Headings
    localparam logic [HEAD_W-1:0] HD_NORTH = 2'd0;
    localparam logic [HEAD_W-1:0] HD_EAST  = 2'd1;
    localparam logic [HEAD_W-1:0] HD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HD_WEST  = 2'd3;

    // Controller commands to the datapath
    typedef struct packed {
        logic                pen_up;
        logic                pen_dn;
        logic                turn_r;
        logic                turn_l;
        logic                mem_rd;    // read grid row
        logic                rd_disp;   // read address from disp_idx, else turtle row
        logic                step;      // mark (if pen down) and advance one cell, stopping at the grid edge
        logic                emit;      // present a result next cycle
        logic                disp;      // result carries a grid row
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [RW-1:0]       disp_idx;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: rtl/tgp_ctrl.sv
// Controller state machine for the turtle grid plotter: decodes commands,
// sequences move steps and display rows, keeps the halt flag.
// Depends on tgp_pkg.
`default_nettype none

module tgp_ctrl
    import tgp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DIST_W-1:0] i_distance,
    output t_dp_cmd                o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MV_RD = 2'd1;
    localparam logic [1:0] S_MV_WR = 2'd2;
    localparam logic [1:0] S_DISP  = 2'd3;

    localparam logic [RW-1:0]     LAST_ROW = RW'(ROWS_USED - 1);
    localparam logic [DIST_W-1:0] ONE_STEP = DIST_W'(1);

    logic [1:0]        r_state, n_state;
    logic [DIST_W-1:0] r_cnt, n_cnt;
    logic [RW-1:0]     r_didx, n_didx;
    logic              r_halted, n_halted;

    assign busy = (r_state != S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_didx   = r_didx;
        n_halted = r_halted;
        o_cmd    = '0;
        o_cmd.last   = 1'b1;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_halted) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_HALTED;
                    end else begin
                        case (i_op)
                            OP_PEN_UP: begin
                                o_cmd.pen_up = 1'b1;
                                o_cmd.emit   = 1'b1;
                            end
                            OP_PEN_DN: begin
                                o_cmd.pen_dn = 1'b1;
                                o_cmd.emit   = 1'b1;
                            end
                            OP_RIGHT: begin
                                o_cmd.turn_r = 1'b1;
                                o_cmd.emit   = 1'b1;
                            end
                            OP_LEFT: begin
                                o_cmd.turn_l = 1'b1;
                                o_cmd.emit   = 1'b1;
                            end
                            OP_MOVE: begin
                                if (i_distance == '0) begin
                                    o_cmd.emit = 1'b1;
                                end else begin
                                    n_cnt   = i_distance;
                                    n_state = S_MV_RD;
                                end
                            end
                            OP_DISPLAY: begin
                                n_didx  = '0;
                                n_state = S_DISP;
                            end
                            OP_END: begin
                                n_halted   = 1'b1;
                                o_cmd.emit = 1'b1;
                            end
                            default: begin
                                n_halted     = 1'b1;
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            // fetch the turtle's current row
            S_MV_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_MV_WR;
            end
            // mark and advance
            S_MV_WR: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - ONE_STEP;
                if (r_cnt == ONE_STEP) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_MV_RD;
                end
            end
            // one row read and one result per cycle
            S_DISP: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.rd_disp  = 1'b1;
                o_cmd.disp_idx = r_didx;
                o_cmd.emit     = 1'b1;
                o_cmd.disp     = 1'b1;
                if (r_didx == LAST_ROW) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.last = 1'b0;
                    n_didx     = r_didx + RW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_halted <= 1'b0;
            r_cnt    <= '0;
            r_didx   <= '0;
        end else begin
            r_state  <= n_state;
            r_halted <= n_halted;
            r_cnt    <= n_cnt;
            r_didx   <= n_didx;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tgp_datapath.sv
// Datapath for the turtle grid plotter: pen, heading, position, the grid
// mark memory with per-row valid bits, and the result registers.
// Depends on tgp_pkg.
`default_nettype none

module tgp_datapath
    import tgp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output logic                      o_result_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [ROW_OW-1:0]         o_row_now,
    output logic [COL_OW-1:0]         o_col_now,
    output logic [HEAD_W-1:0]         o_heading_now,
    output logic                      o_pen_now,
    output logic [ROW_OW-1:0]         o_row_index,
    output logic [BITS_OW-1:0]        o_row_bits,
    output logic                      o_last
);

    localparam logic [RW-1:0] ROW_MAX = RW'(ROWS_USED - 1);
    localparam logic [CW-1:0] COL_MAX = CW'(COLS_USED - 1);

    // Turtle state
    logic              r_pen, n_pen;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;

    // Grid store
    logic [COLS_USED-1:0] mem [ROWS_USED];
    logic [ROWS_USED-1:0] r_row_vld;
    logic [COLS_USED-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [RW-1:0]        rd_addr;
    logic [COLS_USED-1:0] rd_eff;
    logic [COLS_USED-1:0] mark_row;

    // Result registers
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_disp;
    logic [RW-1:0]       r_out_idx;
    logic                r_out_last;

    // Pen, heading and position updates
    always_comb begin
        n_pen  = r_pen;
        n_head = r_head;
        n_row  = r_row;
        n_col  = r_col;
        if (i_cmd.pen_up) n_pen = 1'b0;
        if (i_cmd.pen_dn) n_pen = 1'b1;
        if (i_cmd.turn_r) n_head = r_head + HEAD_W'(1);
        if (i_cmd.turn_l) n_head = r_head - HEAD_W'(1);
        if (i_cmd.step) begin
            case (r_head)
                HD_NORTH: if (r_row != '0)      n_row = r_row - RW'(1);
                HD_EAST:  if (r_col != COL_MAX) n_col = r_col + CW'(1);
                HD_SOUTH: if (r_row != ROW_MAX) n_row = r_row + RW'(1);
                default:  if (r_col != '0)      n_col = r_col - CW'(1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen  <= 1'b0;
            r_head <= HD_SOUTH;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_pen  <= n_pen;
            r_head <= n_head;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // Row read: a row never written reads as zero
    assign rd_addr  = i_cmd.rd_disp ? i_cmd.disp_idx : r_row;
    assign rd_eff   = r_rd_vld ? r_rd_data : '0;
    assign mark_row = rd_eff | (COLS_USED'(1) << r_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.mem_rd) begin
            r_rd_vld <= r_row_vld[rd_addr];
        end
    end

    // Mark write-back at the step cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && r_pen) begin
            mem[r_row] <= mark_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.step && r_pen) begin
            r_row_vld[r_row] <= 1'b1;
        end
    end

    // Result registers, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_disp   <= i_cmd.disp;
            r_out_idx    <= i_cmd.disp ? i_cmd.disp_idx : '0;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_row_now      = ROW_OW'(r_row);
    assign o_col_now      = COL_OW'(r_col);
    assign o_heading_now  = r_head;
    assign o_pen_now      = r_pen;
    assign o_row_index    = ROW_OW'(r_out_idx);
    assign o_row_bits     = r_out_disp ? BITS_OW'(rd_eff) : '0;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/turtle_grid_plotter_top.sv
// Top level of the turtle grid plotter: controller plus datapath.
// Depends on tgp_pkg, tgp_ctrl, tgp_datapath.
//
//  Channel   | Ports                                   | Handshake
//  ----------+-----------------------------------------+-------------------------------
//  command   | i_op, i_distance                        | start high while busy low
//  result    | o_status .. o_last                      | o_result_valid, one cycle each
//
// Pen, turn, end, invalid and halted commands: result strobe in the cycle after
// acceptance; busy stays low, so a command may follow every cycle.
// Move: each unit step is a grid row read, then a mark write-back on the single
// memory port; result in the cycle after the final step.
// Display: one row read and one result per cycle, 32 rows.
// Reset clears the grid through per-row valid bits at once; no clearing pass.
// The receiver cannot stall; results are never held back.
`default_nettype none

module turtle_grid_plotter_top
    import tgp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [DIST_W-1:0]    i_distance,
    output logic                      o_result_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [ROW_OW-1:0]         o_row_now,
    output logic [COL_OW-1:0]         o_col_now,
    output logic [HEAD_W-1:0]         o_heading_now,
    output logic                      o_pen_now,
    output logic [ROW_OW-1:0]         o_row_index,
    output logic [BITS_OW-1:0]        o_row_bits,
    output logic                      o_last
);

    t_dp_cmd cmd;

    // Command sequencing
    tgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_distance (i_distance),
        .o_cmd      (cmd)
    );

    // Turtle state, grid and results
    tgp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_row_now      (o_row_now),
        .o_col_now      (o_col_now),
        .o_heading_now  (o_heading_now),
        .o_pen_now      (o_pen_now),
        .o_row_index    (o_row_index),
        .o_row_bits     (o_row_bits),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
